>>> rtl/cdo_pkg.sv
// Shared types, constants and calendar functions for the date offset block.
package cdo_pkg;

  // Field widths of the transfer payloads.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 16;

  // Running day count: start day plus a signed 16-bit offset needs 17 signed bits.
  localparam int WALK_W = OFF_W + 1;

  // Highest year the walk may reach.
  localparam logic [YEAR_W-1:0] YEAR_LIMIT = 14'd9999;

  // Division by 100 through a reciprocal: q = (y * DIV100_MUL) >> DIV100_SHIFT.
  // Exact for every 14-bit year.
  localparam int DIV100_SHIFT = 20;
  localparam logic [YEAR_W-1:0] DIV100_MUL = 14'd10486;
  localparam int PROD_W = 2 * YEAR_W;
  localparam int QUO_W  = 8;
  localparam int CENT_W = QUO_W + 7;
  localparam logic [CENT_W-1:0] CENTURY = 15'd100;

  // Month codes that the walk treats specially.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Length of December, and the day the walk saturates to.
  localparam logic [DAY_W-1:0] DAYS_DEC  = 5'd31;
  localparam logic [DAY_W-1:0] FIRST_DAY = 5'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture an accepted input transfer
    logic div;    // compute year / 100
    logic leap;   // compute the leap flag of the current year
    logic check;  // record whether the start date is invalid
    logic step;   // move one month
    logic emit;   // load the result register
  } cdo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic invalid;    // start date is not a calendar date
    logic walk_done;  // the day count lies inside the current month
    logic year_wrap;  // the next step crosses a year boundary
    logic ovf_hit;    // the next step leaves the year range
  } cdo_sts_t;

  // Days in a month; months outside 1..12 have no days.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/cdo_if.sv
// Handshake interfaces for the request and response channels.
interface cdo_req_if;
  logic                           valid;
  logic                           ready;
  logic [cdo_pkg::YEAR_W-1:0]     start_year;
  logic [cdo_pkg::MONTH_W-1:0]    start_month;
  logic [cdo_pkg::DAY_W-1:0]      start_day;
  logic signed [cdo_pkg::OFF_W-1:0] day_offset;

  modport source (output valid, start_year, start_month, start_day, day_offset,
                  input ready);
  modport sink   (input valid, start_year, start_month, start_day, day_offset,
                  output ready);
endinterface

interface cdo_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [cdo_pkg::YEAR_W-1:0]  result_year;
  logic [cdo_pkg::MONTH_W-1:0] result_month;
  logic [cdo_pkg::DAY_W-1:0]   result_day;
  logic                        bad_input;
  logic                        year_overflow;

  modport source (output valid, result_year, result_month, result_day, bad_input,
                  year_overflow, input ready);
  modport sink   (input valid, result_year, result_month, result_day, bad_input,
                  year_overflow, output ready);
endinterface

>>> rtl/cdo_ctrl.sv
// Controller state machine that sequences validation and the month walk.
module cdo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  cdo_pkg::cdo_sts_t sts,
  output cdo_pkg::cdo_cmd_t cmd
);
  import cdo_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_LEAP  = 6'b000100,
    S_CHECK = 6'b001000,
    S_WALK  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   walking, walking_next;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next   = state;
    walking_next = walking;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load     = 1'b1;
          walking_next = 1'b0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div    = 1'b1;
        state_next = S_LEAP;
      end
      S_LEAP: begin
        cmd.leap   = 1'b1;
        state_next = walking ? S_WALK : S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.invalid) begin
          state_next = S_EMIT;
        end else begin
          walking_next = 1'b1;
          state_next   = S_WALK;
        end
      end
      S_WALK: begin
        priority if (sts.walk_done) begin
          state_next = S_EMIT;
        end else if (sts.ovf_hit) begin
          cmd.step   = 1'b1;
          state_next = S_EMIT;
        end else if (sts.year_wrap) begin
          // A new year needs its leap flag before the next step.
          cmd.step   = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and response valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      walking   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      walking <= walking_next;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/cdo_dp.sv
// Datapath: date registers, leap-year unit, month step and result register.
module cdo_dp (
  input  logic                              clk,
  input  cdo_pkg::cdo_cmd_t                 cmd,
  output cdo_pkg::cdo_sts_t                 sts,
  input  logic [cdo_pkg::YEAR_W-1:0]        start_year,
  input  logic [cdo_pkg::MONTH_W-1:0]       start_month,
  input  logic [cdo_pkg::DAY_W-1:0]         start_day,
  input  logic signed [cdo_pkg::OFF_W-1:0]  day_offset,
  output logic [cdo_pkg::YEAR_W-1:0]        result_year,
  output logic [cdo_pkg::MONTH_W-1:0]       result_month,
  output logic [cdo_pkg::DAY_W-1:0]         result_day,
  output logic                              bad_input,
  output logic                              year_overflow
);
  import cdo_pkg::*;

  logic [YEAR_W-1:0]        year;
  logic [MONTH_W-1:0]       month;
  logic signed [WALK_W-1:0] day;
  logic [DAY_W-1:0]         day0;
  logic                     backward;
  logic                     bad;
  logic                     ovf;
  logic [QUO_W-1:0]         quo;
  logic                     leap;

  logic [PROD_W-1:0]        prod;
  logic [CENT_W-1:0]        cent_prod;
  logic                     cent;
  logic [DAY_W-1:0]         dim;
  logic [DAY_W-1:0]         dim_prev;
  logic signed [WALK_W-1:0] dim_s;
  logic signed [WALK_W-1:0] dim_prev_s;
  logic signed [WALK_W-1:0] day_init;

  // Year / 100 by reciprocal multiply; the quotient is registered.
  assign prod = {{YEAR_W{1'b0}}, year} * {{YEAR_W{1'b0}}, DIV100_MUL};

  // A year is a century when quotient * 100 gives it back.
  assign cent_prod = {{(CENT_W-QUO_W){1'b0}}, quo} * CENTURY;
  assign cent      = (cent_prod == {{(CENT_W-YEAR_W){1'b0}}, year});

  // Month lengths for the current and the preceding month.
  assign dim        = month_days(month, leap);
  assign dim_prev   = month_days(month - MONTH_JAN, leap);
  assign dim_s      = signed'({{(WALK_W-DAY_W){1'b0}}, dim});
  assign dim_prev_s = signed'({{(WALK_W-DAY_W){1'b0}}, dim_prev});
  assign day_init   = signed'({{(WALK_W-DAY_W){1'b0}}, start_day})
                    + signed'({{(WALK_W-OFF_W){day_offset[OFF_W-1]}}, day_offset});

  // Status for the controller.
  always_comb begin
    sts.invalid   = (month < MONTH_JAN) || (month > MONTH_DEC) || (day0 == '0) ||
                    (day0 > dim) || (year > YEAR_LIMIT);
    sts.walk_done = backward ? (day >= signed'(WALK_W'(1))) : (day <= dim_s);
    sts.year_wrap = backward ? (month == MONTH_JAN) : (month == MONTH_DEC);
    sts.ovf_hit   = sts.year_wrap && (backward ? (year == '0) : (year >= YEAR_LIMIT));
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year     <= start_year;
      month    <= start_month;
      day0     <= start_day;
      day      <= day_init;
      backward <= day_offset[OFF_W-1];
      ovf      <= 1'b0;
    end
    if (cmd.div) begin
      quo <= prod[DIV100_SHIFT +: QUO_W];
    end
    if (cmd.leap) begin
      leap <= (cent && (quo[1:0] == 2'b00)) || (!cent && (year[1:0] == 2'b00));
    end
    if (cmd.check) begin
      bad <= sts.invalid;
    end
    // One month forward or back.
    if (cmd.step) begin
      if (!backward) begin
        if (month == MONTH_DEC) begin
          if (year >= YEAR_LIMIT) begin
            ovf   <= 1'b1;
            year  <= YEAR_LIMIT;
            month <= MONTH_DEC;
            day   <= signed'({{(WALK_W-DAY_W){1'b0}}, DAYS_DEC});
          end else begin
            year  <= year + YEAR_W'(1);
            month <= MONTH_JAN;
            day   <= day - dim_s;
          end
        end else begin
          month <= month + MONTH_W'(1);
          day   <= day - dim_s;
        end
      end else begin
        if (month == MONTH_JAN) begin
          if (year == '0) begin
            ovf   <= 1'b1;
            month <= MONTH_JAN;
            day   <= signed'({{(WALK_W-DAY_W){1'b0}}, FIRST_DAY});
          end else begin
            // December has the same length in every year.
            year  <= year - YEAR_W'(1);
            month <= MONTH_DEC;
            day   <= day + signed'({{(WALK_W-DAY_W){1'b0}}, DAYS_DEC});
          end
        end else begin
          month <= month - MONTH_W'(1);
          day   <= day + dim_prev_s;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (bad) begin
        result_year   <= '0;
        result_month  <= '0;
        result_day    <= '0;
        bad_input     <= 1'b1;
        year_overflow <= 1'b0;
      end else begin
        result_year   <= year;
        result_month  <= month;
        result_day    <= day[DAY_W-1:0];
        bad_input     <= 1'b0;
        year_overflow <= ovf;
      end
    end
  end

endmodule

>>> rtl/calendar_date_day_offset_core.sv
// Top level of the Gregorian date offset block.
//
//   Port  Direction  Transfer contents
//   req   sink       start_year, start_month, start_day, day_offset
//   rsp   source     result_year, result_month, result_day, bad_input, year_overflow
//
// One date is processed at a time. After its transfer an item is checked in S_DIV, S_LEAP
// and S_CHECK; an invalid date then goes straight to S_EMIT. A valid one walks month by
// month in S_WALK until the walk is found finished, and passes S_DIV and S_LEAP again at
// each year boundary crossed (the leap-year unit recomputes year / 100 and the leap flag).
// S_EMIT loads the result, and the next request transfer is taken in S_IDLE.
// Reset is synchronous and clears the controller and the response valid flag.
// A new request is accepted while an earlier result waits on rsp; a finished date
// waits in the controller until the result register frees up.
module calendar_date_day_offset_core (
  input logic       clk,
  input logic       rst,
  cdo_req_if.sink   req,
  cdo_rsp_if.source rsp
);
  import cdo_pkg::*;

  cdo_cmd_t cmd;
  cdo_sts_t sts;

  // Sequencing.
  cdo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Date arithmetic.
  cdo_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .start_year    (req.start_year),
    .start_month   (req.start_month),
    .start_day     (req.start_day),
    .day_offset    (req.day_offset),
    .result_year   (rsp.result_year),
    .result_month  (rsp.result_month),
    .result_day    (rsp.result_day),
    .bad_input     (rsp.bad_input),
    .year_overflow (rsp.year_overflow)
  );

endmodule

>>> rtl/cdo_checker.sv
// Port-level checks on the response channel, bound to the top level.
module cdo_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [cdo_pkg::YEAR_W-1:0]  result_year,
  input logic [cdo_pkg::MONTH_W-1:0] result_month,
  input logic [cdo_pkg::DAY_W-1:0]   result_day,
  input logic                        bad_input,
  input logic                        year_overflow
);
  import cdo_pkg::*;

  // An invalid start date gives an all-zero result with no overflow.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bad_input |-> result_year == '0 && result_month == '0 &&
                               result_day == '0 && !year_overflow)
    else $error("invalid date result is not cleared");

  // A good result is a real month and day within the year range.
  a_good_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !bad_input |-> result_month >= MONTH_JAN && result_month <= MONTH_DEC &&
                                result_day != '0 && result_year <= YEAR_LIMIT)
    else $error("result date out of range");

  // An overflow saturates to one of the two end dates.
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && year_overflow |->
      (result_year == YEAR_LIMIT && result_month == MONTH_DEC && result_day == DAYS_DEC) ||
      (result_year == '0 && result_month == MONTH_JAN && result_day == FIRST_DAY))
    else $error("overflow result is not saturated");

  // A stalled result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_year) &&
                                $stable(result_month) && $stable(result_day) &&
                                $stable(bad_input) && $stable(year_overflow))
    else $error("stalled result changed");

endmodule

bind calendar_date_day_offset_core cdo_checker u_cdo_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .result_year   (rsp.result_year),
  .result_month  (rsp.result_month),
  .result_day    (rsp.result_day),
  .bad_input     (rsp.bad_input),
  .year_overflow (rsp.year_overflow)
);

>>> test/calendar_date_day_offset_core_tb.sv
// Testbench for the date offset core: directed and random dates checked against a predictor.
`timescale 1ns / 100ps

module calendar_date_day_offset_core_tb;
  import cdo_pkg::*;

  // One request transfer and one response transfer.
  typedef struct packed {
    logic [YEAR_W-1:0]        year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic signed [OFF_W-1:0]  offset;
  } date_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               bad_input;
    logic               year_overflow;
  } date_rsp_t;

  localparam int FIRST_MONTH = 1;
  localparam int LAST_MONTH  = 12;
  localparam int MONTH_LENGTH [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int DRAIN_CYCLES = 1400;
  localparam int MAX_REPORTS  = 10;

  logic clk;
  logic rst;

  cdo_req_if req_ch ();
  cdo_rsp_if rsp_ch ();

  calendar_date_day_offset_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  date_rsp_t pending_dates[$];
  int        mismatch_count = 0;
  int        hold_cycles    = 0;
  logic      quiet_mode     = 1'b0;

  // Clock generation.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Number of days in a month under the Gregorian leap-year rule.
  function automatic int days_of_month(input int year, input int month);
    bit leap;
    if (month < FIRST_MONTH || month > LAST_MONTH) return 0;
    leap = (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
    return MONTH_LENGTH[month] + ((month == int'(MONTH_FEB) && leap) ? 1 : 0);
  endfunction

  // Expected response for one request: validity check, then a month-by-month walk.
  function automatic date_rsp_t shift_date(input date_req_t r);
    date_rsp_t res;
    int        y;
    int        m;
    int        d;
    int        limit;
    res   = '0;
    y     = int'(r.year);
    m     = int'(r.month);
    limit = int'(YEAR_LIMIT);
    if (m < FIRST_MONTH || m > LAST_MONTH || r.day == 0 ||
        int'(r.day) > days_of_month(y, m) || y > limit) begin
      res.bad_input = 1'b1;
      return res;
    end
    d = int'(r.day) + int'(r.offset);
    if (r.offset >= 0) begin
      // Forward walk; saturate at the last day of the last year.
      while (!res.year_overflow && d > days_of_month(y, m)) begin
        d -= days_of_month(y, m);
        m++;
        if (m > LAST_MONTH) begin
          m = FIRST_MONTH;
          if (y >= limit) begin
            res.year_overflow = 1'b1;
            y = limit;
            m = LAST_MONTH;
            d = int'(DAYS_DEC);
          end else begin
            y++;
          end
        end
      end
    end else begin
      // Backward walk; saturate at the first day of year zero.
      while (!res.year_overflow && d < 1) begin
        m--;
        if (m < FIRST_MONTH) begin
          m = LAST_MONTH;
          if (y == 0) begin
            res.year_overflow = 1'b1;
            m = FIRST_MONTH;
            d = int'(FIRST_DAY);
          end else begin
            y--;
          end
        end
        if (!res.year_overflow) d += days_of_month(y, m);
      end
    end
    res.year  = y[YEAR_W-1:0];
    res.month = m[MONTH_W-1:0];
    res.day   = d[DAY_W-1:0];
    return res;
  endfunction

  // Drive one request, optionally after an idle burst, and wait for its transfer.
  task automatic send_date(input int year, input int month, input int day, input int offset);
    date_req_t item;
    item.year   = year[YEAR_W-1:0];
    item.month  = month[MONTH_W-1:0];
    item.day    = day[DAY_W-1:0];
    item.offset = offset[OFF_W-1:0];
    @(negedge clk);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.start_year  <= item.year;
    req_ch.start_month <= item.month;
    req_ch.start_day   <= item.day;
    req_ch.day_offset  <= item.offset;
    do @(posedge clk); while (!req_ch.ready);
    pending_dates.push_back(shift_date(item));
  endtask

  // Random request: mostly valid dates, some near the year limits, some noise.
  task automatic send_random_date(input int max_small_offset);
    int year;
    int month;
    int day;
    int offset;
    if ($urandom_range(0, 9) == 0) begin
      year   = $urandom_range(0, 16383);
      month  = $urandom_range(0, 15);
      day    = $urandom_range(0, 31);
      offset = $signed($urandom_range(0, 65535) - 32768);
    end else begin
      case ($urandom_range(0, 9))
        0:       year = $urandom_range(0, 3);
        1:       year = $urandom_range(int'(YEAR_LIMIT) - 3, int'(YEAR_LIMIT));
        2:       year = $urandom_range(0, 99) * 100 + $urandom_range(0, 1);
        default: year = $urandom_range(0, int'(YEAR_LIMIT));
      endcase
      month = $urandom_range(FIRST_MONTH, LAST_MONTH);
      day   = $urandom_range(1, days_of_month(year, month));
      case ($urandom_range(0, 3))
        0:       offset = $urandom_range(0, 65535) - 32768;
        1:       offset = $urandom_range(0, 6000) - 3000;
        default: offset = $urandom_range(0, 2 * max_small_offset) - max_small_offset;
      endcase
    end
    send_date(year, month, day, offset);
  endtask

  // Response ready: random stall bursts, a long hold-off on request, none when quiet.
  initial begin : drive_ready
    int stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (quiet_mode) begin
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each response transfer with the oldest pending expectation.
  initial begin : check_results
    date_rsp_t got;
    date_rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.year          = rsp_ch.result_year;
        got.month         = rsp_ch.result_month;
        got.day           = rsp_ch.result_day;
        got.bad_input     = rsp_ch.bad_input;
        got.year_overflow = rsp_ch.year_overflow;
        if (pending_dates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected response %0d-%0d-%0d bad=%0b ovf=%0b", got.year, got.month,
                     got.day, got.bad_input, got.year_overflow);
        end else begin
          want = pending_dates.pop_front();
          if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
              got.bad_input !== want.bad_input || got.year_overflow !== want.year_overflow) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected %0d-%0d-%0d bad=%0b ovf=%0b, got %0d-%0d-%0d bad=%0b ovf=%0b",
                       want.year, want.month, want.day, want.bad_input, want.year_overflow,
                       got.year, got.month, got.day, got.bad_input, got.year_overflow);
          end
        end
      end
    end
  end

  // Dates that are not on the calendar, including out-of-range years.
  task automatic test_invalid_dates();
    send_date(2023, 0, 10, 5);
    send_date(2023, 13, 1, 5);
    send_date(2023, 15, 31, -1);
    send_date(2023, 4, 0, 1);
    send_date(2023, 4, 31, 1);
    send_date(1900, 2, 29, 0);
    send_date(2001, 2, 29, 3);
    send_date(10000, 1, 1, 1);
    send_date(16383, 12, 31, -32768);
  endtask

  // Leap-year rule: every fourth year, except centuries, except every fourth century.
  task automatic test_leap_years();
    send_date(2000, 2, 28, 1);
    send_date(1900, 2, 28, 1);
    send_date(2024, 3, 1, -1);
    send_date(2100, 3, 1, -1);
    send_date(2000, 2, 29, 366);
    send_date(2023, 6, 15, 0);
    send_date(1999, 12, 31, 1);
  endtask

  // Saturation at both ends of the year range and the largest offsets.
  task automatic test_year_limits();
    send_date(0, 1, 1, -1);
    send_date(0, 1, 1, -32768);
    send_date(0, 12, 31, -365);
    send_date(int'(YEAR_LIMIT), 12, 31, 1);
    send_date(int'(YEAR_LIMIT), 12, 31, 32767);
    send_date(int'(YEAR_LIMIT), 1, 1, 364);
    send_date(5000, 6, 15, 32767);
    send_date(5000, 6, 15, -32768);
  endtask

  // Random dates with random idling on both channels.
  task automatic test_random_dates(input int count);
    repeat (count) send_random_date(400);
  endtask

  // Long response hold-off while requests keep coming, so the input stalls.
  task automatic test_output_backpressure(input int count);
    hold_cycles = 1500;
    repeat (count) send_random_date(60);
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_steady_stream(input int count);
    quiet_mode = 1'b1;
    repeat (count) send_random_date(400);
  endtask

  // Main sequence.
  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.start_year  = '0;
    req_ch.start_month = '0;
    req_ch.start_day   = '0;
    req_ch.day_offset  = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_invalid_dates();
    test_leap_years();
    test_year_limits();
    test_random_dates(400);
    test_output_backpressure(12);
    test_steady_stream(110);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
